FILE: design/sfab_pkg.sv
// Shared types and constants for the spectrum frame average binner.
// Used by the controller, datapath, divider and top level; depends on nothing.
`default_nettype none

package sfab_pkg;

   localparam int FRAME_CNT_W = 4;
   localparam int CFG_NARROW_W = 5;
   localparam int CFG_WIDE_W = 12;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int PIXEL_W = 32;
   localparam logic [CFG_NARROW_W-1:0] CFG_MAX = 5'd16;

   localparam logic [CFG_NARROW_W-1:0] FRAMES_RESET = 5'd1;
   localparam logic [CFG_NARROW_W-1:0] BPP_RESET = 5'd2;

   typedef enum logic [1:0] {
      CSR_FRAMES = 2'd0,
      CSR_BPP    = 2'd1,
      CSR_START  = 2'd2,
      CSR_PIXELS = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_DIV,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic add;
      logic div_start;
      logic update;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic last_frame;
      logic div_done;
      logic group_done;
   } status_type;

   function automatic logic [CFG_NARROW_W-1:0] clamp_1_16(input logic [CFG_NARROW_W-1:0] v);
      logic [CFG_NARROW_W-1:0] r;
      r = v;
      if (v == '0) r = 5'd1;
      else if (v > CFG_MAX) r = CFG_MAX;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/sfab_div.sv
// Restoring divider, one quotient bit per cycle, small divisor (1..16).
// Depends on sfab_pkg for the divisor width.
`default_nettype none

module sfab_div
   import sfab_pkg::*;
#(
   parameter int WIDTH = 28
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire  [WIDTH-1:0]         dividend,
   input  wire  [CFG_NARROW_W-1:0]  divisor,
   output logic [WIDTH-1:0]         quotient,
   output logic                     done
);

   localparam int CntW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]        quo_ff, quo_in;
   logic [CFG_NARROW_W-1:0] rem_ff, rem_in;
   logic [CntW-1:0]         cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CFG_NARROW_W:0]   trial;
   logic                    fits;

   always_comb begin
      trial = {rem_ff, quo_ff[WIDTH-1]};
      fits = trial >= {1'b0, divisor};
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CntW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where the divisor fits
         quo_in = {quo_ff[WIDTH-2:0], fits};
         rem_in = fits ? CFG_NARROW_W'(trial - {1'b0, divisor}) : CFG_NARROW_W'(trial);
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

FILE: design/sfab_ctrl.sv
// Sequencer for the binner: one bin at a time through add, divide (last frame), update, emit (pixel done).
// Depends on sfab_pkg for state, command and status types.
`default_nettype none

module sfab_ctrl
   import sfab_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire             rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ADD;
         end
         ST_ADD: begin
            if (status.in_range && status.last_frame) state_in = ST_DIV;
            else state_in = ST_UPDATE;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = status.group_done ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            cmd.div_start = status.in_range && status.last_frame;
         end
         ST_DIV: begin
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_EMIT: begin
            cmd.load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: design/sfab_dpath.sv
// Datapath: per-bin accumulator memory, frame and group counters, pixel scaling.
// Depends on sfab_pkg and instantiates sfab_div.
`default_nettype none

module sfab_dpath
   import sfab_pkg::*;
#(
   parameter int NUM_BINS = 4096,
   parameter int MAX_PIXELS = 2048,
   parameter int SAMPLE_BITS = 24
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire  [SAMPLE_BITS-1:0]   bin_power,
   input  wire                      frame_end,
   input  wire  [CFG_NARROW_W-1:0]  frames_to_average,
   input  wire  [CFG_NARROW_W-1:0]  bins_per_pixel,
   input  wire  [CFG_WIDE_W-1:0]    start_bin,
   input  wire  [CFG_WIDE_W-1:0]    pixel_count,
   output logic [PIXEL_W-1:0]       pixel_value,
   output logic                     last_pixel
);

   localparam int AccW = SAMPLE_BITS + FRAME_CNT_W;
   // a frame count lowered mid-round leaves averages up to AccW bits, 16 of them per group
   localparam int GrpW = AccW + FRAME_CNT_W;
   localparam int IdxW = $clog2(NUM_BINS);
   localparam int PosW = $clog2(NUM_BINS + 1);
   localparam int PixW = $clog2(MAX_PIXELS + 1);
   localparam int LimW = (PixW > CFG_WIDE_W) ? PixW : CFG_WIDE_W;
   localparam int StartW = (PosW > CFG_WIDE_W) ? PosW : CFG_WIDE_W;
   localparam int ProdW = GrpW + CFG_NARROW_W;

   logic [AccW-1:0] acc_mem [NUM_BINS];

   logic [SAMPLE_BITS-1:0]  power_ff, power_in;
   logic                    frame_end_ff, frame_end_in;
   logic [AccW-1:0]         rd_data_ff;
   logic [AccW-1:0]         total_ff, total_in;
   logic [FRAME_CNT_W-1:0]  frame_cnt_ff, frame_cnt_in;
   logic [PosW-1:0]         bin_pos_ff, bin_pos_in;
   logic [GrpW-1:0]         group_sum_ff, group_sum_in;
   logic [FRAME_CNT_W-1:0]  group_fill_ff, group_fill_in;
   logic [PixW-1:0]         pix_pos_ff, pix_pos_in;
   logic [GrpW-1:0]         pix_sum_ff, pix_sum_in;
   logic                    pix_last_ff, pix_last_in;
   logic [PIXEL_W-1:0]      out_value_ff, out_value_in;
   logic                    out_last_ff, out_last_in;

   logic [CFG_NARROW_W-1:0] nframes;
   logic [CFG_NARROW_W-1:0] nbpp;
   logic [LimW-1:0]         limit;
   logic [IdxW-1:0]         idx;
   logic                    in_range;
   logic                    last_frame;
   logic                    eligible;
   logic [AccW-1:0]         div_quo;
   logic                    div_done;
   logic [AccW-1:0]         bin_value;
   logic [GrpW-1:0]         sum_new;
   logic [CFG_NARROW_W-1:0] fill_new;
   logic [PixW-1:0]         pix_pos_nx;
   logic                    group_done;
   logic [ProdW-1:0]        product;

   assign nframes = clamp_1_16(frames_to_average);
   assign nbpp = clamp_1_16(bins_per_pixel);
   assign limit = (LimW'(pixel_count) < LimW'(MAX_PIXELS)) ?
                  LimW'(pixel_count) : LimW'(MAX_PIXELS);
   assign idx = bin_pos_ff[IdxW-1:0];
   assign in_range = bin_pos_ff < PosW'(NUM_BINS);
   assign last_frame = ({1'b0, frame_cnt_ff} + CFG_NARROW_W'(1)) >= nframes;

   // totals stay within AccW bits since at most 16 frames are summed
   assign total_in = (frame_cnt_ff == '0) ? AccW'(power_ff) : rd_data_ff + AccW'(power_ff);

   sfab_div #(
      .WIDTH(AccW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (total_in),
      .divisor  (nframes),
      .quotient (div_quo),
      .done     (div_done)
   );

   assign bin_value = last_frame ? div_quo : total_ff;
   assign eligible = in_range && last_frame &&
                     (StartW'(bin_pos_ff) >= StartW'(start_bin)) &&
                     (LimW'(pix_pos_ff) < limit);
   assign sum_new = group_sum_ff + GrpW'(bin_value);
   assign fill_new = {1'b0, group_fill_ff} + CFG_NARROW_W'(1);
   assign pix_pos_nx = pix_pos_ff + PixW'(1);
   assign group_done = eligible && (fill_new >= nbpp);
   assign product = {{GrpW{1'b0}}, nbpp} * {{CFG_NARROW_W{1'b0}}, pix_sum_ff};

   assign status.in_range = in_range;
   assign status.last_frame = last_frame;
   assign status.div_done = div_done;
   assign status.group_done = group_done;

   always_comb begin
      power_in = power_ff;
      frame_end_in = frame_end_ff;
      frame_cnt_in = frame_cnt_ff;
      bin_pos_in = bin_pos_ff;
      group_sum_in = group_sum_ff;
      group_fill_in = group_fill_ff;
      pix_pos_in = pix_pos_ff;
      pix_sum_in = pix_sum_ff;
      pix_last_in = pix_last_ff;
      out_value_in = out_value_ff;
      out_last_in = out_last_ff;

      if (cmd.capture) begin
         power_in = bin_power;
         frame_end_in = frame_end;
      end

      if (cmd.update) begin
         if (eligible) begin
            if (group_done) begin
               pix_sum_in = sum_new;
               pix_last_in = LimW'(pix_pos_nx) == limit;
               pix_pos_in = pix_pos_nx;
               group_sum_in = '0;
               group_fill_in = '0;
            end else begin
               group_sum_in = sum_new;
               group_fill_in = fill_new[FRAME_CNT_W-1:0];
            end
         end
         if (in_range) bin_pos_in = bin_pos_ff + PosW'(1);
         // frame end drops the open group, rewinds all positions and steps the frame count
         if (frame_end_ff) begin
            bin_pos_in = '0;
            group_sum_in = '0;
            group_fill_in = '0;
            pix_pos_in = '0;
            frame_cnt_in = last_frame ? '0 : frame_cnt_ff + FRAME_CNT_W'(1);
         end
      end

      if (cmd.load_out) begin
         out_value_in = PIXEL_W'(product);
         out_last_in = pix_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= acc_mem[idx];
      if (cmd.update && in_range) begin
         acc_mem[idx] <= bin_value;
      end
   end

   always_ff @(posedge clock) begin
      power_ff <= power_in;
      frame_end_ff <= frame_end_in;
      if (cmd.add) total_ff <= total_in;
      pix_sum_ff <= pix_sum_in;
      pix_last_ff <= pix_last_in;
      out_value_ff <= out_value_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         frame_cnt_ff <= '0;
         bin_pos_ff <= '0;
         group_sum_ff <= '0;
         group_fill_ff <= '0;
         pix_pos_ff <= '0;
      end else begin
         frame_cnt_ff <= frame_cnt_in;
         bin_pos_ff <= bin_pos_in;
         group_sum_ff <= group_sum_in;
         group_fill_ff <= group_fill_in;
         pix_pos_ff <= pix_pos_in;
      end
   end

   assign pixel_value = out_value_ff;
   assign last_pixel = out_last_ff;

endmodule

`default_nettype wire

FILE: design/spectrum_frame_average_binner_top.sv
// Top level of the spectrum frame average binner: register block and wiring.
// Depends on sfab_pkg; instantiates sfab_ctrl and sfab_dpath.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_bin_power, req_frame_end
//   rsp       out        rsp_valid/rsp_ready  rsp_pixel_value, rsp_last_pixel
//   csr       in/out     psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// One bin at a time. A bin outside the last frame of a round goes through accept,
// accumulator add and update; an in-range bin on the last frame also runs the
// bit-serial divider between add and update, and an emit step follows when the
// bin closes a pixel. The next bin is taken while a pixel waits in the output
// register; a second pixel stalls in the emit step until rsp_ready. Reset clears
// counters, resets the CSRs; the accumulator memory needs no clearing.
`default_nettype none

module spectrum_frame_average_binner_top
   import sfab_pkg::*;
#(
   parameter int NUM_BINS = 4096,
   parameter int MAX_PIXELS = 2048,
   parameter int SAMPLE_BITS = 24
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire  [SAMPLE_BITS-1:0]  req_bin_power,
   input  wire                     req_frame_end,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic [PIXEL_W-1:0]      rsp_pixel_value,
   output logic                    rsp_last_pixel,
   input  wire                     psel,
   input  wire                     penable,
   input  wire                     pwrite,
   input  wire  [CSR_ADDR_W-1:0]   paddr,
   input  wire  [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   logic [CFG_NARROW_W-1:0] frames_ff, frames_in;
   logic [CFG_NARROW_W-1:0] bpp_ff, bpp_in;
   logic [CFG_WIDE_W-1:0]   start_ff, start_in;
   logic [CFG_WIDE_W-1:0]   pixels_ff, pixels_in;
   logic                    csr_write;
   csr_index_type           csr_index;
   cmd_type                 cmd;
   status_type              status;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      frames_in = frames_ff;
      bpp_in = bpp_ff;
      start_in = start_ff;
      pixels_in = pixels_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAMES: frames_in = pwdata[CFG_NARROW_W-1:0];
            CSR_BPP:    bpp_in = pwdata[CFG_NARROW_W-1:0];
            CSR_START:  start_in = pwdata[CFG_WIDE_W-1:0];
            CSR_PIXELS: pixels_in = pwdata[CFG_WIDE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_FRAMES: prdata = CSR_DATA_W'(frames_ff);
         CSR_BPP:    prdata = CSR_DATA_W'(bpp_ff);
         CSR_START:  prdata = CSR_DATA_W'(start_ff);
         CSR_PIXELS: prdata = CSR_DATA_W'(pixels_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
         bpp_ff <= BPP_RESET;
         start_ff <= '0;
         pixels_ff <= '0;
      end else begin
         frames_ff <= frames_in;
         bpp_ff <= bpp_in;
         start_ff <= start_in;
         pixels_ff <= pixels_in;
      end
   end

   sfab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sfab_dpath #(
      .NUM_BINS    (NUM_BINS),
      .MAX_PIXELS  (MAX_PIXELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .bin_power         (req_bin_power),
      .frame_end         (req_frame_end),
      .frames_to_average (frames_ff),
      .bins_per_pixel    (bpp_ff),
      .start_bin         (start_ff),
      .pixel_count       (pixels_ff),
      .pixel_value       (rsp_pixel_value),
      .last_pixel        (rsp_last_pixel)
   );

endmodule

`default_nettype wire
